[design/kred_pkg.sv]
// Package for the boot keyboard report to key event block.
// Holds key and queue types and fixed constants; no dependencies.
package kred_pkg;

  // Widest key slot count that the report format carries
  localparam int unsigned MaxSlots   = 6;
  // One release and one press per slot
  localparam int unsigned EvSlots    = 2 * MaxSlots;
  localparam int unsigned EvIdxW     = $clog2(EvSlots);
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QDepth + 1);
  localparam logic [6:0]  ReportMinLen = 7'd8;
  localparam logic [7:0]  ThreshReset  = 8'd3;

  typedef logic [7:0]        key_t;
  typedef logic [6:0]        len_t;
  typedef logic [EvIdxW-1:0] ev_idx_t;
  typedef logic [QCntW-1:0]  q_cnt_t;

  // Pending events of one report: bit 2i is the release of slot i,
  // bit 2i+1 the press of slot i, with the matching key code.
  typedef struct packed {
    logic [EvSlots-1:0] mask;
    key_t [EvSlots-1:0] keys;
    key_t               modifier;
  } ev_batch_t;

  // Queue status toward both neighbors
  typedef struct packed {
    logic   push_ready;
    logic   pop_valid;
    q_cnt_t count;
  } q_status_t;

endpackage

[design/kred_if.sv]
// Handshake channels of the keyboard report block: report in, event out.
// Depends on kred_pkg for key and length types.
interface kred_in_if;
  logic              valid;
  logic              ready;
  kred_pkg::len_t    report_length;
  kred_pkg::key_t    modifier_bits;
  kred_pkg::key_t    key_slot_0;
  kred_pkg::key_t    key_slot_1;
  kred_pkg::key_t    key_slot_2;
  kred_pkg::key_t    key_slot_3;
  kred_pkg::key_t    key_slot_4;
  kred_pkg::key_t    key_slot_5;

  modport source (output valid, report_length, modifier_bits, key_slot_0, key_slot_1,
                  key_slot_2, key_slot_3, key_slot_4, key_slot_5, input ready);
  modport sink   (input valid, report_length, modifier_bits, key_slot_0, key_slot_1,
                  key_slot_2, key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

interface kred_out_if;
  logic           valid;
  logic           ready;
  kred_pkg::key_t event_key;
  kred_pkg::key_t event_modifier;
  logic           event_pressed;
  logic           last_event;

  modport source (output valid, event_key, event_modifier, event_pressed, last_event,
                  input ready);
  modport sink   (input valid, event_key, event_modifier, event_pressed, last_event,
                  output ready);
endinterface

[design/kred_front.sv]
// Front end: accepts reports, diffs them against the stored keys and
// queues the resulting event mask. Depends on kred_pkg and kred_in_if.
module kred_front #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  kred_in_if.sink             in_if,
  input  logic                push_ready_i,
  output logic                push_valid_o,
  output kred_pkg::ev_batch_t push_data_o
);

  kred_pkg::key_t thresh_q;
  kred_pkg::key_t prev_q [KEY_SLOTS];
  kred_pkg::key_t new_keys [kred_pkg::MaxSlots];
  kred_pkg::ev_batch_t batch;
  logic accept;
  logic long_enough;

  assign new_keys[0] = in_if.key_slot_0;
  assign new_keys[1] = in_if.key_slot_1;
  assign new_keys[2] = in_if.key_slot_2;
  assign new_keys[3] = in_if.key_slot_3;
  assign new_keys[4] = in_if.key_slot_4;
  assign new_keys[5] = in_if.key_slot_5;

  assign in_if.ready  = push_ready_i;
  assign accept       = in_if.valid && in_if.ready;
  assign long_enough  = in_if.report_length >= kred_pkg::ReportMinLen;

  // Release/press classification per slot, all slots in parallel
  always_comb begin
    logic old_in_new;
    logic new_in_old;
    batch          = '0;
    batch.modifier = in_if.modifier_bits;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      old_in_new = 1'b0;
      new_in_old = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        old_in_new = old_in_new | (prev_q[i] == new_keys[j]);
        new_in_old = new_in_old | (new_keys[i] == prev_q[j]);
      end
      batch.mask[2*i]     = (prev_q[i] > thresh_q) && !old_in_new;
      batch.mask[2*i + 1] = (new_keys[i] > thresh_q) && !new_in_old;
      batch.keys[2*i]     = prev_q[i];
      batch.keys[2*i + 1] = new_keys[i];
    end
  end

  // Valid-length reports with no event still update stored keys, queue nothing
  assign push_valid_o = accept && long_enough && (batch.mask != '0);
  assign push_data_o  = batch;

  // Threshold register and stored keys
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= kred_pkg::ThreshReset;
      for (int i = 0; i < KEY_SLOTS; i++) prev_q[i] <= '0;
    end else begin
      if (cfg_we_i) thresh_q <= cfg_wdata_i;
      if (accept && long_enough) begin
        for (int i = 0; i < KEY_SLOTS; i++) prev_q[i] <= new_keys[i];
      end
    end
  end

endmodule

[design/kred_queue.sv]
// Short queue of event batches between front and back end.
// Depends on kred_pkg.
module kred_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kred_pkg::ev_batch_t push_data_i,
  input  logic                pop_i,
  output kred_pkg::ev_batch_t pop_data_o,
  output kred_pkg::q_status_t status_o
);

  kred_pkg::ev_batch_t          mem_q [kred_pkg::QDepth];
  logic [kred_pkg::QPtrW-1:0]   wr_ptr_q;
  logic [kred_pkg::QPtrW-1:0]   rd_ptr_q;
  kred_pkg::q_cnt_t             count_q;
  logic                         push_fire;
  logic                         pop_fire;

  assign status_o.push_ready = count_q != kred_pkg::q_cnt_t'(kred_pkg::QDepth);
  assign status_o.pop_valid  = count_q != '0;
  assign status_o.count      = count_q;
  assign push_fire  = push_i && status_o.push_ready;
  assign pop_fire   = pop_i && status_o.pop_valid;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer wrap at the queue depth
  function automatic logic [kred_pkg::QPtrW-1:0] next_ptr(
    input logic [kred_pkg::QPtrW-1:0] p
  );
    if (p == kred_pkg::QPtrW'(kred_pkg::QDepth - 1)) return '0;
    return p + 1'b1;
  endfunction

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_fire)  rd_ptr_q <= next_ptr(rd_ptr_q);
      unique case ({push_fire, pop_fire})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_fire) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[design/kred_back.sv]
// Back end: walks a batch's pending event mask, one event per cycle unless
// stalled, into a registered output. Depends on kred_pkg and kred_out_if.
module kred_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  kred_pkg::ev_batch_t pop_data_i,
  output logic                pop_o,
  kred_out_if.source          out_if
);

  logic [kred_pkg::EvSlots-1:0] mask_q;
  kred_pkg::key_t               keys_q [kred_pkg::EvSlots];
  kred_pkg::key_t               mod_q;
  logic                         out_valid_q;
  kred_pkg::key_t               out_key_q;
  kred_pkg::key_t               out_mod_q;
  logic                         out_pressed_q;
  logic                         out_last_q;

  logic                         advance;
  logic                         fire;
  kred_pkg::ev_idx_t            idx;
  logic [kred_pkg::EvSlots-1:0] rest;

  assign advance = !out_valid_q || out_if.ready;
  assign fire    = advance && (mask_q != '0);
  assign rest    = mask_q & (mask_q - 1'b1);
  assign pop_o   = (mask_q == '0) || (fire && (rest == '0));

  // Lowest pending event comes first
  always_comb begin
    idx = '0;
    for (int b = kred_pkg::EvSlots - 1; b >= 0; b--) begin
      if (mask_q[b]) idx = kred_pkg::ev_idx_t'(b);
    end
  end

  // Work mask and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && pop_valid_i) mask_q <= pop_data_i.mask;
      else if (fire)            mask_q <= rest;
      if (fire)              out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o && pop_valid_i) begin
      for (int k = 0; k < kred_pkg::EvSlots; k++) keys_q[k] <= pop_data_i.keys[k];
      mod_q <= pop_data_i.modifier;
    end
    if (fire) begin
      out_key_q     <= keys_q[idx];
      out_pressed_q <= idx[0];
      out_mod_q     <= idx[0] ? mod_q : '0;
      out_last_q    <= rest == '0;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.event_key      = out_key_q;
  assign out_if.event_modifier = out_mod_q;
  assign out_if.event_pressed  = out_pressed_q;
  assign out_if.last_event     = out_last_q;

endmodule

[design/keyboard_report_key_event_diff.sv]
// Boot keyboard report to key press/release events.
// A report's first event passes the batch queue, work mask and output register.
// Throughput: a report per cycle while the 2-entry batch queue has room; events
// leave at one per cycle while the output is taken.
// Reset: threshold 3, stored keys all zero, queue and output empty.
// Depends on kred_pkg, kred_if, kred_front, kred_queue and kred_back.
module keyboard_report_key_event_diff #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  kred_in_if.sink    in_if,
  kred_out_if.source out_if
);

  logic                push_valid;
  kred_pkg::ev_batch_t push_data;
  logic                pop;
  kred_pkg::ev_batch_t pop_data;
  kred_pkg::q_status_t q_st;

  // Front end: classify reports
  kred_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_if        (in_if),
    .push_ready_i (q_st.push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  // Batch queue
  kred_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_st)
  );

  // Back end: emit events
  kred_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_st.pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_if      (out_if)
  );

`ifndef SYNTH
  // Full queue must stall the input
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_st.count == kred_pkg::q_cnt_t'(kred_pkg::QDepth)) |-> !in_if.ready)
    else $error("report accepted while batch queue full");

  // Short reports never queue events
  a_short_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && (in_if.report_length < kred_pkg::ReportMinLen))
    |-> !push_valid)
    else $error("short report produced events");

  // Queue fill grows by one on a push without a pop
  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && q_st.push_ready && !(pop && q_st.pop_valid))
    |=> (q_st.count == $past(q_st.count) + kred_pkg::q_cnt_t'(1)))
    else $error("queue count missed a push");
`endif

endmodule

[tb/tb_top.sv]
// Testbench for the boot keyboard report to key event block.
// Depends on kred_pkg, kred_if and keyboard_report_key_event_diff.
`timescale 1ns / 1ps

module tb_top;

  typedef kred_pkg::key_t [kred_pkg::MaxSlots-1:0] key_row_t;

  typedef struct packed {
    kred_pkg::len_t len;
    kred_pkg::key_t mod;
    key_row_t       keys;
  } report_t;

  typedef struct packed {
    kred_pkg::key_t key;
    kred_pkg::key_t modifier;
    logic           pressed;
    logic           last;
  } evt_item_t;

  localparam int DrainGap  = 16;
  localparam int LongHold  = 300;
  localparam int IdlePct   = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  // tb-side drive registers, known from time zero
  logic    src_valid  = 1'b0;
  report_t drv_report = '0;
  logic    sink_ready = 1'b0;

  kred_in_if  rpt_if ();
  kred_out_if evt_if ();

  assign rpt_if.valid         = src_valid;
  assign rpt_if.report_length = drv_report.len;
  assign rpt_if.modifier_bits = drv_report.mod;
  assign rpt_if.key_slot_0    = drv_report.keys[0];
  assign rpt_if.key_slot_1    = drv_report.keys[1];
  assign rpt_if.key_slot_2    = drv_report.keys[2];
  assign rpt_if.key_slot_3    = drv_report.keys[3];
  assign rpt_if.key_slot_4    = drv_report.keys[4];
  assign rpt_if.key_slot_5    = drv_report.keys[5];
  assign evt_if.ready         = sink_ready;

  keyboard_report_key_event_diff #(
    .KEY_SLOTS(kred_pkg::MaxSlots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (rpt_if),
    .out_if     (evt_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow state of the block
  kred_pkg::key_t thresh_model = kred_pkg::ThreshReset;
  key_row_t       held_keys    = '0;

  report_t   report_q[$];
  evt_item_t key_events_q[$];
  int        mism_cnt = 0;

  // Shared knobs between stimulus and the two side processes
  bit no_idle     = 1'b0;
  bit hold_toggle = 1'b0;

  key_row_t last_gen_keys = '0;

  function automatic bit key_in_row(key_row_t row, kred_pkg::key_t k);
    for (int i = 0; i < kred_pkg::MaxSlots; i++) begin
      if (row[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected events of one accepted report; short reports change nothing
  task automatic predict_key_events(input report_t r);
    evt_item_t ev;
    int first;
    first = key_events_q.size();
    if (r.len < kred_pkg::ReportMinLen) return;
    for (int i = 0; i < kred_pkg::MaxSlots; i++) begin
      if (held_keys[i] > thresh_model && !key_in_row(r.keys, held_keys[i])) begin
        ev = '{key: held_keys[i], modifier: 8'd0, pressed: 1'b0, last: 1'b0};
        key_events_q.push_back(ev);
      end
      if (r.keys[i] > thresh_model && !key_in_row(held_keys, r.keys[i])) begin
        ev = '{key: r.keys[i], modifier: r.mod, pressed: 1'b1, last: 1'b0};
        key_events_q.push_back(ev);
      end
    end
    held_keys = r.keys;
    if (key_events_q.size() > first) key_events_q[key_events_q.size()-1].last = 1'b1;
  endtask

  function automatic report_t mk_report(int len, int mod, int k0, int k1, int k2,
                                        int k3, int k4, int k5);
    report_t r;
    r.len     = kred_pkg::len_t'(len);
    r.mod     = kred_pkg::key_t'(mod);
    r.keys[0] = kred_pkg::key_t'(k0);
    r.keys[1] = kred_pkg::key_t'(k1);
    r.keys[2] = kred_pkg::key_t'(k2);
    r.keys[3] = kred_pkg::key_t'(k3);
    r.keys[4] = kred_pkg::key_t'(k4);
    r.keys[5] = kred_pkg::key_t'(k5);
    return r;
  endfunction

  // Random report: mostly full-length, keys clustered near the threshold and
  // reused from the previous report so presses and releases overlap
  function automatic report_t rand_report();
    report_t r;
    int pick;
    int v;
    r.len = ($urandom_range(0, 99) < 15) ? kred_pkg::len_t'($urandom_range(0, 7))
                                         : kred_pkg::len_t'($urandom_range(8, 64));
    r.mod = kred_pkg::key_t'($urandom_range(0, 255));
    for (int i = 0; i < kred_pkg::MaxSlots; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        r.keys[i] = last_gen_keys[$urandom_range(0, kred_pkg::MaxSlots-1)];
      end else if (pick < 45) begin
        r.keys[i] = 8'd0;
      end else if (pick < 75) begin
        v = int'(thresh_model) + int'($urandom_range(0, 8)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        r.keys[i] = kred_pkg::key_t'(v);
      end else begin
        r.keys[i] = kred_pkg::key_t'($urandom_range(0, 255));
      end
    end
    last_gen_keys = r.keys;
    return r;
  endfunction

  // Report driver: predicts on acceptance, then offers the next item
  always @(posedge clk_i) begin : report_drv
    bit offer;
    if (!rst_ni) begin
      src_valid <= 1'b0;
    end else begin
      offer = src_valid;
      if (src_valid && rpt_if.ready) begin
        predict_key_events(drv_report);
        offer = 1'b0;
      end
      if (!offer && report_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
        drv_report <= report_q.pop_front();
        offer = 1'b1;
      end
      src_valid <= offer;
    end
  end

  // Event monitor and ready generator with an optional long hold-off
  always @(posedge clk_i) begin : event_mon
    evt_item_t exp_ev;
    bit rdy;
    bit hold_seen;
    int hold_left;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      hold_seen = hold_toggle;
      hold_left = 0;
    end else begin
      if (evt_if.valid && sink_ready) begin
        if (key_events_q.size() == 0) begin
          $display("%0t: unexpected event key %h mod %h pressed %b last %b", $time,
                   evt_if.event_key, evt_if.event_modifier, evt_if.event_pressed,
                   evt_if.last_event);
          mism_cnt++;
        end else begin
          exp_ev = key_events_q.pop_front();
          if (evt_if.event_key !== exp_ev.key) begin
            $display("%0t: event_key expected %h actual %h", $time, exp_ev.key,
                     evt_if.event_key);
            mism_cnt++;
          end
          if (evt_if.event_modifier !== exp_ev.modifier) begin
            $display("%0t: event_modifier expected %h actual %h", $time, exp_ev.modifier,
                     evt_if.event_modifier);
            mism_cnt++;
          end
          if (evt_if.event_pressed !== exp_ev.pressed) begin
            $display("%0t: event_pressed expected %b actual %b", $time, exp_ev.pressed,
                     evt_if.event_pressed);
            mism_cnt++;
          end
          if (evt_if.last_event !== exp_ev.last) begin
            $display("%0t: last_event expected %b actual %b", $time, exp_ev.last,
                     evt_if.last_event);
            mism_cnt++;
          end
        end
      end
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        hold_left = LongHold;
        rdy = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = no_idle || ($urandom_range(0, 99) >= IdlePct);
      end
      sink_ready <= rdy;
    end
  end

  // Wait until every item is taken and every event has come, then let the
  // block settle in case a short report is still in flight
  task automatic wait_drain();
    while (report_q.size() > 0 || src_valid || key_events_q.size() > 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_threshold(input kred_pkg::key_t v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    thresh_model  = v;
  endtask

  task automatic push_random(input int n);
    repeat (n) report_q.push_back(rand_report());
  endtask

  initial begin : stimulus
    kred_pkg::key_t phase_thresh[7];
    int             phase_items[7];
    phase_thresh = '{8'd0, 8'd255, kred_pkg::key_t'($urandom_range(4, 250)), 8'd3, 8'h80,
                     kred_pkg::key_t'($urandom_range(0, 255)), 8'd1};
    phase_items  = '{60, 20, 60, 60, 50, 60, 60};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed reports at the reset threshold
    report_q.push_back(mk_report(0, 'hFF, 10, 11, 12, 13, 14, 15));   // short, ignored
    report_q.push_back(mk_report(7, 'h00, 10, 11, 12, 13, 14, 15));   // short, ignored
    report_q.push_back(mk_report(8, 'h01, 4, 5, 6, 7, 8, 9));          // presses just over
    report_q.push_back(mk_report(8, 'h02, 9, 8, 7, 6, 5, 4));          // no change
    report_q.push_back(mk_report(64, 'h00, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF)); // dup press
    report_q.push_back(mk_report(8, 'hA5, 3, 3, 2, 1, 0, 'hFF));       // keys move, no event
    report_q.push_back(mk_report(8, 'h5A, 0, 0, 0, 0, 0, 0));          // one release
    report_q.push_back(mk_report(8, 'h80, 'hAA, 'h55, 'hAA, 'h55, 'h80, 'h7F));
    report_q.push_back(mk_report(8, 'h7F, 'h55, 'hAA, 4, 3, 'h80, 1));
    report_q.push_back(mk_report(0, 'h33, 0, 0, 0, 0, 0, 0));          // short, state kept
    report_q.push_back(mk_report(8, 'h00, 0, 0, 0, 0, 0, 0));          // all released
    report_q.push_back(mk_report(8, 'hFF, 10, 11, 12, 13, 14, 15));
    report_q.push_back(mk_report(63, 'hC3, 20, 21, 22, 23, 24, 25));   // twelve events
    report_q.push_back(mk_report(8, 'h3C, 25, 24, 23, 22, 21, 20));    // no change
    report_q.push_back(mk_report(8, 'h00, 'hFE, 'hFE, 'hFE, 'h01, 'h02, 'h03));
    report_q.push_back(mk_report(8, 'h00, 0, 0, 0, 0, 0, 0));
    wait_drain();

    for (int p = 0; p < 7; p++) begin
      write_threshold(phase_thresh[p]);
      if (p == 2) hold_toggle = ~hold_toggle;
      no_idle = (p == 3);
      if (p == 4) begin
        // sender pauses mid-phase until all events are out
        push_random(phase_items[p] / 2);
        wait_drain();
        push_random(phase_items[p] - phase_items[p] / 2);
      end else begin
        push_random(phase_items[p]);
      end
      wait_drain();
    end
    no_idle = 1'b0;

    if (mism_cnt == 0 && key_events_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
